>>> rtl/core/cwf_pkg.sv
package cwf_pkg;

  localparam int unsigned MaxWidthDefault = 1024;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned RowW   = 48;
  localparam int unsigned WidthW = 11;
  localparam int unsigned HeightW = 16;
  localparam int unsigned ConvW  = 28;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  // products and partial sums
  localparam int unsigned ProdW = CoefW + PixW + 1;
  localparam int unsigned RsumW = ProdW + 2;
  localparam int unsigned TsumW = RsumW + 2;

  localparam logic [WidthW-1:0]  WidthRst  = 11'd1024;
  localparam logic [HeightW-1:0] HeightRst = 16'd1024;
  localparam logic [RowW-1:0]    CoefTopRst = 48'h0000_0000_0000;
  localparam logic [RowW-1:0]    CoefMidRst = 48'h0000_0100_0000;
  localparam logic [RowW-1:0]    CoefBotRst = 48'h0000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_COEF_TOP = 3'd2,
    REG_COEF_MID = 3'd3,
    REG_COEF_BOT = 3'd4
  } cfg_reg_e;

  // k = 0 is the left tap, held in the upper bits
  function automatic logic signed [CoefW-1:0] coef_at(input logic [RowW-1:0] row,
                                                      input int unsigned k);
    logic [CoefW-1:0] raw;
    raw = row[RowW-CoefW-CoefW*k +: CoefW];
    return $signed(raw);
  endfunction

endpackage

>>> rtl/core/conv2d_window_filter_top.sv
// 3x3 convolution over a raster stream of 8-bit grey pixels.
// Input stream: s_axis_tdata carries one pixel, s_axis_tuser marks the first
// pixel of a frame. Each pixel at (row r, col c) completes the window centred
// on (r-1, c-1); pixels in row 0 or column 0 give no result.
// Output stream: m_axis_tdata carries the signed Q.8 sum, m_axis_tuser is set
// for interior centres (border centres give zero), m_axis_tlast marks the
// result caused by the frame's last pixel.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write width, height and the
// three coefficient rows; write only while no request is in flight.
// Throughput: one pixel per clock unless the receiver stalls. m_axis_tvalid rises
// once its pixel has passed the line store read, products and row sums; the
// final sum goes straight into the output register. The two line stores share
// one 16-bit wide memory, read at the pixel's column on accept and written
// back as the pixel moves on; back-to-back same-column hits are forwarded.
// Reset clears counters, window and pipeline valids and loads the identity
// mask at 1024x1024; the line store is not cleared, so no start-up pass.
// A stalled receiver holds the output register; bubbles inside the pipe are
// squeezed out before s_axis_tready drops.
module conv2d_window_filter_top #(
  parameter int unsigned MAX_WIDTH = cwf_pkg::MaxWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cwf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cwf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel
  input  logic                          s_axis_tuser,  // [0] frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [27:0] conv_value
  output logic                          m_axis_tuser,  // [0] interior
  output logic                          m_axis_tlast   // frame_end
);
  import cwf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  // configuration registers
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [RowW-1:0]    coef_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthRst;
      height_q  <= HeightRst;
      coef_q[0] <= CoefTopRst;
      coef_q[1] <= CoefMidRst;
      coef_q[2] <= CoefBotRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:    width_q   <= cfg_data_i[WidthW-1:0];
        REG_HEIGHT:   height_q  <= cfg_data_i[HeightW-1:0];
        REG_COEF_TOP: coef_q[0] <= cfg_data_i[RowW-1:0];
        REG_COEF_MID: coef_q[1] <= cfg_data_i[RowW-1:0];
        REG_COEF_BOT: coef_q[2] <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [WW-1:0]      w_eff;
  logic [HeightW-1:0] h_eff;

  always_comb begin
    if (width_q < WidthW'(3)) begin
      w_eff = WW'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q < HeightW'(3)) ? HeightW'(3) : height_q;
  end

  // pipeline handshake
  logic ov_q, v1_q, v2_q, v3_q;
  logic en_o, en3, en2, en1, acc;

  assign en_o = !ov_q || m_axis_tready;
  assign en3  = !v3_q || en_o;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign s_axis_tready = en1;
  assign acc = s_axis_tvalid && en1;

  // position counters
  logic [CW-1:0]      col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;
  logic [WW-1:0]      c_cur, c_inc;
  logic [HeightW:0]   r_wrap, r_inc;
  logic [HeightW-1:0] r_cur;
  logic               emit_in, int_in, fe_in;

  always_comb begin
    c_cur  = s_axis_tuser ? '0 : WW'(col_q);
    r_wrap = s_axis_tuser ? '0 : {1'b0, row_q};
    if (c_cur >= w_eff) begin
      c_cur  = '0;
      r_wrap = r_wrap + 1'b1;
    end
    r_cur = (r_wrap >= {1'b0, h_eff}) ? '0 : r_wrap[HeightW-1:0];
    c_inc = c_cur + 1'b1;
    r_inc = {1'b0, r_cur} + 1'b1;
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[HeightW-1:0];
    end else begin
      col_d = c_inc[CW-1:0];
      row_d = r_cur;
    end
    emit_in = (r_cur != '0) && (c_cur != '0);
    int_in  = (r_cur >= HeightW'(2)) && (c_cur >= WW'(2));
    fe_in   = (r_cur == h_eff - 1'b1) && (c_cur == w_eff - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store memory: [15:8] upper line, [7:0] lower line
  logic [2*PixW-1:0] ls_mem [MAX_WIDTH];
  logic [2*PixW-1:0] rd_q, fwd_data_q, ls_rd, ls_wr;
  logic              fwd_q;
  logic [CW-1:0]     a1_q;
  logic [PixW-1:0]   p1_q;
  logic              emit1_q, int1_q, fe1_q;

  assign ls_rd = fwd_q ? fwd_data_q : rd_q;
  assign ls_wr = {ls_rd[PixW-1:0], p1_q};

  always_ff @(posedge clk_i) begin
    if (en1) begin
      rd_q <= ls_mem[c_cur[CW-1:0]];
    end
    if (v1_q && en2) begin
      ls_mem[a1_q] <= ls_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else if (en1) begin
      v1_q  <= acc;
      fwd_q <= acc && v1_q && en2 && (a1_q == c_cur[CW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a1_q       <= c_cur[CW-1:0];
      p1_q       <= s_axis_tdata;
      emit1_q    <= emit_in;
      int1_q     <= int_in;
      fe1_q      <= fe_in;
      fwd_data_q <= ls_wr;
    end
  end

  // window: columns 0 and 1 kept, column 2 is the read data and the new pixel
  logic [PixW-1:0] win_q [3][2];
  logic [PixW-1:0] col_new [3];

  assign col_new[0] = ls_rd[2*PixW-1:PixW];
  assign col_new[1] = ls_rd[PixW-1:0];
  assign col_new[2] = p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < 3; u++) begin
        win_q[u][0] <= '0;
        win_q[u][1] <= '0;
      end
    end else if (v1_q && en2) begin
      for (int u = 0; u < 3; u++) begin
        win_q[u][0] <= win_q[u][1];
        win_q[u][1] <= col_new[u];
      end
    end
  end

  // nine products
  logic signed [ProdW-1:0] prod_d [9];
  logic signed [ProdW-1:0] prod_q [9];
  logic                    emit2_q, int2_q, fe2_q;

  always_comb begin
    for (int u = 0; u < 3; u++) begin
      prod_d[3*u]   = ProdW'(coef_at(coef_q[u], 0)) * ProdW'($signed({1'b0, win_q[u][0]}));
      prod_d[3*u+1] = ProdW'(coef_at(coef_q[u], 1)) * ProdW'($signed({1'b0, win_q[u][1]}));
      prod_d[3*u+2] = ProdW'(coef_at(coef_q[u], 2)) * ProdW'($signed({1'b0, col_new[u]}));
      if (!int1_q) begin
        prod_d[3*u]   = '0;
        prod_d[3*u+1] = '0;
        prod_d[3*u+2] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      prod_q  <= prod_d;
      emit2_q <= emit1_q;
      int2_q  <= int1_q;
      fe2_q   <= fe1_q;
    end
  end

  // row sums
  logic signed [RsumW-1:0] rsum_q [3];
  logic                    emit3_q, int3_q, fe3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      for (int u = 0; u < 3; u++) begin
        rsum_q[u] <= RsumW'(prod_q[3*u]) + RsumW'(prod_q[3*u+1]) + RsumW'(prod_q[3*u+2]);
      end
      emit3_q <= emit2_q;
      int3_q  <= int2_q;
      fe3_q   <= fe2_q;
    end
  end

  // final sum and output register
  logic signed [TsumW-1:0] tsum;
  logic [ConvW-1:0]        conv_q;
  logic                    int_o_q, fe_o_q;

  assign tsum = TsumW'(rsum_q[0]) + TsumW'(rsum_q[1]) + TsumW'(rsum_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_o) begin
      ov_q <= v3_q && emit3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && v3_q) begin
      conv_q  <= tsum[ConvW-1:0];
      int_o_q <= int3_q;
      fe_o_q  <= fe3_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{(32 - ConvW){1'b0}}, conv_q};
  assign m_axis_tuser  = int_o_q;
  assign m_axis_tlast  = fe_o_q;

`ifndef NO_ASSERTIONS
  a_fwd_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> v1_q)
    else $error("forwarding flagged with no request in line store stage");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> v1_q)
    else $error("accepted request missing from line store stage");

  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("border result not zero");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> (v1_q && $stable(a1_q)))
    else $error("line store stage lost a stalled request");
`endif

endmodule
